>>> sv/vrot_pkg.sv
`default_nettype none

package vrot_pkg;

  // Field and register widths.
  localparam int COMP_W        = 24;
  localparam int ANG_W         = 16;
  localparam int CORDIC_STAGES = 16;

  // Internal fixed-point formats: Q30 coefficients, residual angle in 2^-32 turn.
  localparam int FRAC_Q      = 30;
  localparam int COEF_W      = 32;
  localparam int RESID_W     = 34;
  localparam int STAGE_IDX_W = $clog2(CORDIC_STAGES);
  localparam int ATAN_IDX_W  = 5;
  localparam int ROT_DEPTH   = 4;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // Infinite-stage CORDIC gain 0.60725293 in Q30.
  localparam logic signed [COEF_W-1:0] GAIN_Q30 = COEF_W'(652032874);

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [29:0] ATAN_TURNS [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef logic signed [COMP_W-1:0]  comp_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [RESID_W-1:0] resid_t;

  typedef enum logic [1:0] {
    Q_FIRST,
    Q_SECOND,
    Q_THIRD,
    Q_FOURTH
  } quad_t;

  // State of one CORDIC sine/cosine evaluation.
  typedef struct packed {
    coef_t  cx;
    coef_t  cy;
    resid_t rz;
    quad_t  quad;
  } cordic_t;

  // Contents of one cell of the chain: the vector and both angle evaluations.
  typedef struct packed {
    logic    vld;
    comp_t   vx;
    comp_t   vy;
    comp_t   vz;
    cordic_t pol;
    cordic_t azi;
  } cell_t;

  // One finished result.
  typedef struct packed {
    logic  vld;
    comp_t ox;
    comp_t oy;
    comp_t oz;
    logic  sat;
  } result_t;

endpackage

`default_nettype wire

>>> sv/vrot_in_if.sv
`default_nettype none

interface vrot_in_if import vrot_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t in_x;
  comp_t in_y;
  comp_t in_z;

  modport source (output valid, output in_x, output in_y, output in_z, input ready);
  modport sink (input valid, input in_x, input in_y, input in_z, output ready);
endinterface

`default_nettype wire

>>> sv/vrot_out_if.sv
`default_nettype none

interface vrot_out_if import vrot_pkg::*; ();
  logic  valid;
  logic  ready;
  comp_t out_x;
  comp_t out_y;
  comp_t out_z;
  logic  saturated;

  modport source (output valid, output out_x, output out_y, output out_z,
                  output saturated, input ready);
  modport sink (input valid, input out_x, input out_y, input out_z,
                input saturated, output ready);
endinterface

`default_nettype wire

>>> sv/vrot_cordic_cell.sv
`default_nettype none

module vrot_cordic_cell import vrot_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   run,
  input  logic [STAGE_IDX_W-1:0] stage,
  input  cell_t                  cell_in,
  output cell_t                  cell_out
);

  cell_t cell_next;

  // One micro-rotation; the sign of the residual angle picks the direction.
  function automatic cordic_t micro_rotate(input cordic_t s,
                                           input logic [STAGE_IDX_W-1:0] sh);
    coef_t   dx;
    coef_t   dy;
    resid_t  step_angle;
    cordic_t r;
    dx = s.cx >>> sh;
    dy = s.cy >>> sh;
    step_angle = resid_t'(ATAN_TURNS[ATAN_IDX_W'(sh)]);
    r.quad = s.quad;
    if (s.rz[RESID_W-1]) begin
      r.cx = s.cx + dy;
      r.cy = s.cy - dx;
      r.rz = s.rz + step_angle;
    end else begin
      r.cx = s.cx - dy;
      r.cy = s.cy + dx;
      r.rz = s.rz - step_angle;
    end
    return r;
  endfunction

  // Both angles advance one step; the vector rides along unchanged.
  always_comb begin
    cell_next     = cell_in;
    cell_next.pol = micro_rotate(cell_in.pol, stage);
    cell_next.azi = micro_rotate(cell_in.azi, stage);
  end

  // Only the valid bit is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.vld <= 1'b0;
    end else if (run) begin
      cell_out <= cell_next;
    end
  end

endmodule

`default_nettype wire

>>> sv/vrot_rotate.sv
`default_nettype none

module vrot_rotate import vrot_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    run,
  input  cell_t   cell_in,
  output result_t res
);

  localparam int PROD1_W = COMP_W + COEF_W;
  localparam int SUM1_W  = PROD1_W + 1;
  localparam int X1_W    = SUM1_W - FRAC_Q;
  localparam int PROD2_W = X1_W + COEF_W;
  localparam int SUM2_W  = PROD2_W + 1;
  localparam int X2_W    = SUM2_W - FRAC_Q;

  localparam logic signed [SUM1_W-1:0] RND1 = SUM1_W'(1) <<< (FRAC_Q - 1);
  localparam logic signed [SUM2_W-1:0] RND2 = SUM2_W'(1) <<< (FRAC_Q - 1);
  localparam logic signed [X2_W-1:0]   CLIP_HI =
    {{(X2_W - COMP_W + 1){1'b0}}, {(COMP_W - 1){1'b1}}};
  localparam logic signed [X2_W-1:0]   CLIP_LO = ~CLIP_HI;

  typedef struct packed {
    coef_t cos_v;
    coef_t sin_v;
  } trig_t;

  typedef struct packed {
    comp_t val;
    logic  hit;
  } clip_t;

  // Quadrant fold of the CORDIC outputs into cosine and sine.
  function automatic trig_t trig_of(input cordic_t c);
    trig_t t;
    case (c.quad)
      Q_FIRST: begin
        t.cos_v = c.cx;
        t.sin_v = c.cy;
      end
      Q_SECOND: begin
        t.cos_v = -c.cy;
        t.sin_v = c.cx;
      end
      Q_THIRD: begin
        t.cos_v = -c.cx;
        t.sin_v = -c.cy;
      end
      default: begin
        t.cos_v = c.cy;
        t.sin_v = -c.cx;
      end
    endcase
    return t;
  endfunction

  function automatic clip_t clip(input logic signed [X2_W-1:0] v);
    clip_t r;
    if (v > CLIP_HI) begin
      r.val = CLIP_HI[COMP_W-1:0];
      r.hit = 1'b1;
    end else if (v < CLIP_LO) begin
      r.val = CLIP_LO[COMP_W-1:0];
      r.hit = 1'b1;
    end else begin
      r.val = v[COMP_W-1:0];
      r.hit = 1'b0;
    end
    return r;
  endfunction

  trig_t trig_pol;
  trig_t trig_azi;

  logic                       a_vld;
  logic signed [PROD1_W-1:0]  a_xc;
  logic signed [PROD1_W-1:0]  a_zs;
  logic signed [PROD1_W-1:0]  a_zc;
  logic signed [PROD1_W-1:0]  a_xs;
  comp_t                      a_y;
  trig_t                      a_azi;

  logic signed [SUM1_W-1:0]   sum_x1;
  logic signed [SUM1_W-1:0]   sum_z1;

  logic                       b_vld;
  logic signed [X1_W-1:0]     b_x1;
  logic signed [X1_W-1:0]     b_z1;
  comp_t                      b_y;
  trig_t                      b_azi;

  logic                       c_vld;
  logic signed [PROD2_W-1:0]  c_x1c;
  logic signed [PROD2_W-1:0]  c_ys;
  logic signed [PROD2_W-1:0]  c_x1s;
  logic signed [PROD2_W-1:0]  c_yc;
  logic signed [X1_W-1:0]     c_z1;

  logic signed [SUM2_W-1:0]   sum_x2;
  logic signed [SUM2_W-1:0]   sum_y2;
  logic signed [X2_W-1:0]     x2;
  logic signed [X2_W-1:0]     y2;
  clip_t                      clip_x;
  clip_t                      clip_y;
  clip_t                      clip_z;

  assign trig_pol = trig_of(cell_in.pol);
  assign trig_azi = trig_of(cell_in.azi);

  // Stage A: the four products of the rotation about Y.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (run) begin
      a_vld <= cell_in.vld;
      a_xc  <= cell_in.vx * trig_pol.cos_v;
      a_zs  <= cell_in.vz * trig_pol.sin_v;
      a_zc  <= cell_in.vz * trig_pol.cos_v;
      a_xs  <= cell_in.vx * trig_pol.sin_v;
      a_y   <= cell_in.vy;
      a_azi <= trig_azi;
    end
  end

  // Stage B: sums rounded half up to the unsaturated Y-rotation result.
  assign sum_x1 = SUM1_W'(a_xc) + SUM1_W'(a_zs) + RND1;
  assign sum_z1 = SUM1_W'(a_zc) - SUM1_W'(a_xs) + RND1;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else if (run) begin
      b_vld <= a_vld;
      b_x1  <= sum_x1[SUM1_W-1:FRAC_Q];
      b_z1  <= sum_z1[SUM1_W-1:FRAC_Q];
      b_y   <= a_y;
      b_azi <= a_azi;
    end
  end

  // Stage C: the four products of the rotation about Z.
  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else if (run) begin
      c_vld <= b_vld;
      c_x1c <= b_x1 * b_azi.cos_v;
      c_ys  <= b_y * b_azi.sin_v;
      c_x1s <= b_x1 * b_azi.sin_v;
      c_yc  <= b_y * b_azi.cos_v;
      c_z1  <= b_z1;
    end
  end

  // Stage D: round, saturate and flag any clipping.
  assign sum_x2 = SUM2_W'(c_x1c) - SUM2_W'(c_ys) + RND2;
  assign sum_y2 = SUM2_W'(c_x1s) + SUM2_W'(c_yc) + RND2;
  assign x2     = sum_x2[SUM2_W-1:FRAC_Q];
  assign y2     = sum_y2[SUM2_W-1:FRAC_Q];
  assign clip_x = clip(x2);
  assign clip_y = clip(y2);
  assign clip_z = clip(X2_W'(c_z1));

  always_ff @(posedge clk) begin
    if (rst) begin
      res.vld <= 1'b0;
    end else if (run) begin
      res.vld <= c_vld;
      res.ox  <= clip_x.val;
      res.oy  <= clip_y.val;
      res.oz  <= clip_z.val;
      res.sat <= clip_x.hit | clip_y.hit | clip_z.hit;
    end
  end

endmodule

`default_nettype wire

>>> sv/vector_rotate_y_then_z.sv
// Channel    Dir  Handshake       Payload
// vec_in     in   valid / ready   in_x, in_y, in_z
// vec_out    out  valid / ready   out_x, out_y, out_z, saturated
// apb        in   psel / penable  polar_angle at 0x0, azimuth_angle at 0x4
//
// One request is taken per cycle while vec_in.ready is high. After a request
// is taken, its result passes through each CORDIC cell, then the multiply and
// round stages and the output register.
// Each request carries both angles through the cell chain, so an angle write
// applies from the next request on. Reset is synchronous and clears valid bits
// and the angle registers. A stalled output fills a one-entry skid register;
// vec_in.ready is low only while that skid register is full.
`default_nettype none

module vector_rotate_y_then_z import vrot_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  vrot_in_if.sink            vec_in,
  vrot_out_if.source         vec_out
);

  typedef enum logic {
    REG_POLAR,
    REG_AZIMUTH
  } reg_idx_t;

  localparam comp_t SAT_MAX = {1'b0, {(COMP_W - 1){1'b1}}};
  localparam comp_t SAT_MIN = ~SAT_MAX;

  logic [ANG_W-1:0] polar_angle;
  logic [ANG_W-1:0] azimuth_angle;
  reg_idx_t         reg_idx;
  logic             cfg_write;

  cell_t   chain [CORDIC_STAGES+1];
  result_t res;
  result_t o_buf;
  result_t s_buf;
  logic    run;

  // Start state of a CORDIC evaluation: quadrant and residual from the angle.
  function automatic cordic_t cordic_init(input logic [ANG_W-1:0] ang);
    cordic_t c;
    c.quad = quad_t'(ang[ANG_W-1 -: 2]);
    c.cx   = GAIN_Q30;
    c.cy   = '0;
    c.rz   = resid_t'(ang[ANG_W-3:0]) <<< (32 - ANG_W);
    return c;
  endfunction

  // Register file on the APB port.
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      polar_angle   <= '0;
      azimuth_angle <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_POLAR:   polar_angle   <= pwdata[ANG_W-1:0];
        REG_AZIMUTH: azimuth_angle <= pwdata[ANG_W-1:0];
        default:     polar_angle   <= polar_angle;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POLAR:   prdata = PDATA_W'(polar_angle);
      REG_AZIMUTH: prdata = PDATA_W'(azimuth_angle);
      default:     prdata = '0;
    endcase
  end

  // The whole pipeline advances unless the skid register is holding a result.
  assign run          = ~s_buf.vld;
  assign vec_in.ready = run;

  // Entry of the cell chain.
  always_comb begin
    chain[0].vld = vec_in.valid;
    chain[0].vx  = vec_in.in_x;
    chain[0].vy  = vec_in.in_y;
    chain[0].vz  = vec_in.in_z;
    chain[0].pol = cordic_init(polar_angle);
    chain[0].azi = cordic_init(azimuth_angle);
  end

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
    vrot_cordic_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .run      (run),
      .stage    (STAGE_IDX_W'(k)),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  vrot_rotate u_rotate (
    .clk     (clk),
    .rst     (rst),
    .run     (run),
    .cell_in (chain[CORDIC_STAGES]),
    .res     (res)
  );

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_buf.vld <= 1'b0;
      s_buf.vld <= 1'b0;
    end else if (~o_buf.vld | vec_out.ready) begin
      if (s_buf.vld) begin
        o_buf     <= s_buf;
        s_buf.vld <= 1'b0;
      end else begin
        o_buf <= res;
      end
    end else if (run & res.vld) begin
      s_buf <= res;
    end
  end

  assign vec_out.valid     = o_buf.vld;
  assign vec_out.out_x     = o_buf.ox;
  assign vec_out.out_y     = o_buf.oy;
  assign vec_out.out_z     = o_buf.oz;
  assign vec_out.saturated = o_buf.sat;

  // The skid register is only ever filled behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_buf.vld |-> o_buf.vld)
    else $error("skid register full while output register is empty");

  // A taken request enters the first cell.
  a_accept_enters_chain: assert property (@(posedge clk) disable iff (rst)
    (vec_in.valid && vec_in.ready) |=> chain[1].vld)
    else $error("accepted request did not enter the cell chain");

  // A result arriving at a stalled output lands in the skid register.
  a_stall_caught: assert property (@(posedge clk) disable iff (rst)
    (run && res.vld && o_buf.vld && !vec_out.ready) |=> s_buf.vld)
    else $error("result lost while output stalled");

  // The saturation flag implies a component sits at a limit.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (vec_out.valid && vec_out.saturated) |->
      (vec_out.out_x == SAT_MAX || vec_out.out_x == SAT_MIN ||
       vec_out.out_y == SAT_MAX || vec_out.out_y == SAT_MIN ||
       vec_out.out_z == SAT_MAX || vec_out.out_z == SAT_MIN))
    else $error("saturation flag without a clipped component");

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import vrot_pkg::*;

  localparam int LATENCY     = 21;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REG_POLAR   = 0;
  localparam int REG_AZIMUTH = 1;
  localparam int STRETCHES   = 8;
  localparam int STRETCH_LEN = 64;

  // Sender idle and receiver stall percentages for each pacing mode.
  localparam int SEND_IDLE [4] = '{0, 82, 0, 25};
  localparam int RECV_STALL[4] = '{0, 0, 82, 25};

  localparam comp_t C_MAX = 24'sh7FFFFF;
  localparam comp_t C_MIN = 24'sh800000;
  localparam comp_t C_ONE = 24'sh001000;

  // CORDIC start value (gain-compensated) and arctangent steps in 2^-32 turn.
  localparam longint CORDIC_START = 64'sd652032874;
  localparam longint ROUND_HALF   = 64'sd536870912;
  localparam longint ARC_STEP [CORDIC_STAGES] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861
  };

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
    logic  sat;
  } vec_result_t;

  typedef struct packed {
    logic [ANG_W-1:0] pol;
    logic [ANG_W-1:0] azi;
    comp_t            vx;
    comp_t            vy;
    comp_t            vz;
    logic             given;
    vec_result_t      want;
  } stim_row_t;

  localparam vec_result_t ZERO_RES = '0;
  localparam int DIRECTED_ROWS = 20;

  // Hand-picked vectors; zero vectors have their result written out.
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{16'h0000, 16'h0000, 0, 0, 0, 1'b1, ZERO_RES},
    '{16'h0000, 16'h0000, C_MAX, C_MAX, C_MAX, 1'b0, ZERO_RES},
    '{16'h0000, 16'h0000, C_MIN, C_MIN, C_MIN, 1'b0, ZERO_RES},
    '{16'h0000, 16'h0000, C_ONE, 0, 0, 1'b0, ZERO_RES},
    '{16'h0000, 16'h0000, 0, C_ONE, 0, 1'b0, ZERO_RES},
    '{16'h0000, 16'h0000, 0, 0, C_ONE, 1'b0, ZERO_RES},
    '{16'h0000, 16'h0000, C_MAX, C_MIN, -1, 1'b0, ZERO_RES},
    '{16'h4000, 16'h4000, C_ONE, comp_t'(2 * C_ONE), comp_t'(3 * C_ONE), 1'b0, ZERO_RES},
    '{16'h8000, 16'h8000, C_ONE, comp_t'(2 * C_ONE), comp_t'(3 * C_ONE), 1'b0, ZERO_RES},
    '{16'hC000, 16'hC000, C_ONE, comp_t'(2 * C_ONE), comp_t'(3 * C_ONE), 1'b0, ZERO_RES},
    '{16'hFFFF, 16'hFFFF, 0, 0, 0, 1'b1, ZERO_RES},
    '{16'hFFFF, 16'hFFFF, C_MAX, C_MIN, C_MAX, 1'b0, ZERO_RES},
    '{16'h2000, 16'h0000, C_MAX, 0, C_MAX, 1'b0, ZERO_RES},
    '{16'h2000, 16'h2000, C_MIN, C_MIN, C_MIN, 1'b0, ZERO_RES},
    '{16'h2000, 16'h2000, C_MAX, C_MAX, C_MIN, 1'b0, ZERO_RES},
    '{16'h6000, 16'hA000, 1, -1, 0, 1'b0, ZERO_RES},
    '{16'h0001, 16'h3FFF, C_MAX, 1, C_MIN, 1'b0, ZERO_RES},
    '{16'h4001, 16'hBFFF, -1, C_MAX, 1, 1'b0, ZERO_RES},
    '{16'h8000, 16'h0000, C_MIN, 0, 0, 1'b0, ZERO_RES},
    '{16'h0000, 16'h8000, 0, 0, 0, 1'b1, ZERO_RES}
  };

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  vrot_in_if  in_ch ();
  vrot_out_if out_ch ();

  vector_rotate_y_then_z dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .vec_in  (in_ch),
    .vec_out (out_ch)
  );

  vec_result_t      rotated_q[$];
  logic [ANG_W-1:0] polar_cfg;
  logic [ANG_W-1:0] azimuth_cfg;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               cycles;
  int               errors;
  int               vectors_sent;
  int               results_seen;
  int               clipped_seen;
  int               settings_used;

  // Clock and cycle count.
  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Sine and cosine of an angle register value, Q30, by quadrant folding and CORDIC.
  function automatic void angle_sincos(input logic [ANG_W-1:0] ang,
                                       output longint c, output longint s);
    longint cx;
    longint cy;
    longint rz;
    longint nx;
    quad_t  qd;
    qd = quad_t'(ang[ANG_W-1 -: 2]);
    rz = longint'(ang[ANG_W-3:0]) << (32 - ANG_W);
    cx = CORDIC_START;
    cy = 0;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      if (rz >= 0) begin
        nx = cx - (cy >>> i);
        cy = cy + (cx >>> i);
        rz = rz - ARC_STEP[i];
      end else begin
        nx = cx + (cy >>> i);
        cy = cy - (cx >>> i);
        rz = rz + ARC_STEP[i];
      end
      cx = nx;
    end
    case (qd)
      Q_FIRST: begin
        c = cx;
        s = cy;
      end
      Q_SECOND: begin
        c = -cy;
        s = cx;
      end
      Q_THIRD: begin
        c = -cx;
        s = -cy;
      end
      default: begin
        c = cy;
        s = -cx;
      end
    endcase
  endfunction

  // Sum of two component-by-Q30 products, scaled back and rounded half up.
  function automatic longint round_dot(input longint a, input longint ka,
                                       input longint b, input longint kb);
    return (a * ka + b * kb + ROUND_HALF) >>> 30;
  endfunction

  function automatic comp_t clip_comp(input longint v, inout logic flag);
    if (v > longint'(C_MAX)) begin
      flag = 1'b1;
      return C_MAX;
    end
    if (v < longint'(C_MIN)) begin
      flag = 1'b1;
      return C_MIN;
    end
    return comp_t'(v);
  endfunction

  // Rotation about Y by the polar angle, then about Z by the azimuth angle.
  function automatic vec_result_t rotate_vector(input comp_t vx, input comp_t vy,
                                                input comp_t vz);
    longint      cp, sp, ca, sa;
    longint      x1, z1, x2, y2;
    vec_result_t r;
    angle_sincos(polar_cfg, cp, sp);
    angle_sincos(azimuth_cfg, ca, sa);
    x1 = round_dot(longint'(vx), cp, longint'(vz), sp);
    z1 = round_dot(longint'(vz), cp, longint'(vx), -sp);
    x2 = round_dot(x1, ca, longint'(vy), -sa);
    y2 = round_dot(x1, sa, longint'(vy), ca);
    r.sat = 1'b0;
    r.x = clip_comp(x2, r.sat);
    r.y = clip_comp(y2, r.sat);
    r.z = clip_comp(z1, r.sat);
    return r;
  endfunction

  function automatic comp_t random_comp();
    comp_t v;
    case ($urandom_range(3))
      0: v = comp_t'($urandom);
      1: v = comp_t'(int'($urandom_range(16383)) - 8192);
      2: v = $urandom_range(1) ? C_MAX : C_MIN;
      default: begin
        v = C_MAX - comp_t'($urandom_range(4095));
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // One register bus transfer; called at a clock edge, returns at the clock edge that follows the access.
  task automatic apb_xfer(input logic wr, input int idx, input logic [PDATA_W-1:0] wdata,
                          output logic [PDATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write an angle with junk in the unused upper bits, then read it back.
  task automatic write_angle(input int idx, input logic [ANG_W-1:0] ang);
    logic [PDATA_W-1:0] rd;
    apb_xfer(1'b1, idx, {16'($urandom), ang}, rd);
    if (idx == REG_POLAR) polar_cfg = ang;
    else azimuth_cfg = ang;
    apb_xfer(1'b0, idx, '0, rd);
    if (rd !== PDATA_W'(ang))
      report_mismatch($sformatf("register %0d read back %0h, expected %0h", idx, rd, ang));
  endtask

  task automatic program_angles(input logic [ANG_W-1:0] pol, input logic [ANG_W-1:0] azi);
    write_angle(REG_POLAR, pol);
    write_angle(REG_AZIMUTH, azi);
    settings_used++;
  endtask

  // Offer one request with random idle cycles ahead of it; record its expected result.
  task automatic send_vector(input comp_t vx, input comp_t vy, input comp_t vz,
                             input logic given, input vec_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_x  <= vx;
    in_ch.in_y  <= vy;
    in_ch.in_z  <= vz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rotated_q.push_back(given ? want : rotate_vector(vx, vy, vz));
    vectors_sent++;
  endtask

  // Drop valid and wait until every result has come back.
  task automatic drain_stream();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (rotated_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_pacing(input int mode);
    send_idle_pct  = SEND_IDLE[mode];
    recv_stall_pct = RECV_STALL[mode];
  endtask

  // Result side: random backpressure and comparison with the oldest expectation.
  always @(posedge clk) begin
    vec_result_t want;
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.saturated) clipped_seen++;
      if (rotated_q.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = rotated_q.pop_front();
        if (out_ch.out_x !== want.x)
          report_mismatch($sformatf("result %0d out_x: got %0d, expected %0d",
                                    results_seen, out_ch.out_x, want.x));
        if (out_ch.out_y !== want.y)
          report_mismatch($sformatf("result %0d out_y: got %0d, expected %0d",
                                    results_seen, out_ch.out_y, want.y));
        if (out_ch.out_z !== want.z)
          report_mismatch($sformatf("result %0d out_z: got %0d, expected %0d",
                                    results_seen, out_ch.out_z, want.z));
        if (out_ch.saturated !== want.sat)
          report_mismatch($sformatf("result %0d saturated: got %0b, expected %0b",
                                    results_seen, out_ch.saturated, want.sat));
      end
    end
  end

  // Watchdog.
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycles, rotated_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Main sequence: reset, directed table, then random stretches.
  initial begin
    logic [ANG_W-1:0] pol;
    logic [ANG_W-1:0] azi;
    errors        = 0;
    vectors_sent  = 0;
    results_seen  = 0;
    clipped_seen  = 0;
    settings_used = 1;
    polar_cfg     = '0;
    azimuth_cfg   = '0;
    set_pacing(3);
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_ch.valid  <= 1'b0;
    in_ch.in_x   <= '0;
    in_ch.in_y   <= '0;
    in_ch.in_z   <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table; angles change only with the pipeline empty.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].pol != polar_cfg || DIRECTED[r].azi != azimuth_cfg) begin
        drain_stream();
        program_angles(DIRECTED[r].pol, DIRECTED[r].azi);
      end
      send_vector(DIRECTED[r].vx, DIRECTED[r].vy, DIRECTED[r].vz,
                  DIRECTED[r].given, DIRECTED[r].want);
    end

    // Random stretches, each with its own angle pair and one of the four pacing modes.
    for (int ph = 0; ph < STRETCHES; ph++) begin
      drain_stream();
      case (ph)
        0: begin
          pol = '1;
          azi = '1;
        end
        1: begin
          pol = '0;
          azi = '1;
        end
        2: begin
          pol = '1;
          azi = '0;
        end
        3: begin
          pol = 16'h4000;
          azi = 16'h8000;
        end
        default: begin
          pol = ANG_W'($urandom);
          azi = ANG_W'($urandom);
        end
      endcase
      program_angles(pol, azi);
      set_pacing(ph % 4);
      for (int n = 0; n < STRETCH_LEN; n++)
        send_vector(random_comp(), random_comp(), random_comp(), 1'b0, ZERO_RES);
    end

    // Let the pipeline empty and watch for stray results.
    set_pacing(0);
    drain_stream();
    repeat (2 * LATENCY) @(posedge clk);

    $display("Sent %0d vectors under %0d angle settings and four pacing modes.",
             vectors_sent, settings_used);
    $display("Checked %0d results, %0d clipped; %0d mismatches.",
             results_seen, clipped_seen, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
sv/vrot_pkg.sv
sv/vrot_in_if.sv
sv/vrot_out_if.sv
sv/vrot_cordic_cell.sv
sv/vrot_rotate.sv
sv/vector_rotate_y_then_z.sv
tb/sv/tb_top.sv
